// File: rtl/mur_pkg.sv
// ----------------------------------------------------------------------------
// Multiplexed ultrasonic ranger package
// Shared constants, channel codes and the result word layout.
// ----------------------------------------------------------------------------
package mur_pkg;

  localparam int unsigned COUNTER_BITS_DEFAULT = 16;
  localparam int unsigned NUM_CHANNELS         = 3;
  localparam int unsigned TIME_BITS            = 16;
  localparam int unsigned TICKS_BITS           = 16;
  localparam int unsigned IN_TDATA_BITS        = 8;
  localparam int unsigned OUT_TDATA_BITS       = 56;

  localparam logic [TIME_BITS-1:0]  TIMEOUT_CODE  = 16'hFFFF;
  localparam logic [TIME_BITS-1:0]  MAX_WIDTH     = 16'hFFFE;
  localparam logic [TICKS_BITS-1:0] TRIGGER_RESET = 16'd22;

  typedef enum logic [1:0] {
    CH_LEFT  = 2'd0,
    CH_RIGHT = 2'd1,
    CH_FRONT = 2'd2
  } channel_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] front_time;
    logic [TIME_BITS-1:0] right_time;
    logic [TIME_BITS-1:0] left_time;
    channel_e             active_sensor;
    logic [2:0]           trigger_lines;
  } mur_result_t;

endpackage

// File: rtl/multiplexed_ultrasonic_ranger.sv
// ----------------------------------------------------------------------------
// Multiplexed ultrasonic ranger
// Each slave word is one counter tick with a sample of the three echo pins.
// The block rotates through the left, right and front channels on every
// counter wrap, drives their trigger lines and times each echo pulse. It
// takes one word per clock cycle unless both registers are full and the
// output is stalled; a word is held first in the input register and then in
// the output register, with the whole tick worked out in one pass between them.
// ----------------------------------------------------------------------------
module multiplexed_ultrasonic_ranger
  import mur_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [TICKS_BITS-1:0]     cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // echo_pins[2:0], zero fill[7:3]
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // trigger_lines[2:0], active_sensor[4:3], left_time[20:5],
  // right_time[36:21], front_time[52:37], zero fill[55:53]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic [TICKS_BITS-1:0] ticks_q;
  logic                  in_valid_q, in_valid_d;
  logic [2:0]            pins_q;
  logic                  free;
  logic                  advance;
  mur_result_t           result;

  assign advance       = in_valid_q && free;
  assign s_axis_tready = !in_valid_q || free;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= TRIGGER_RESET;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pins_q <= s_axis_tdata[2:0];
    end
  end

  mur_step #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .echo_pins_i    (pins_q),
    .trigger_ticks_i(ticks_q),
    .result_o       (result)
  );

  mur_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .result_i     (result),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  a_trigger_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
    else $error("more than one trigger line is high");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] != 2'd3))
    else $error("active channel code out of range");

  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed word did not reach the output register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both stages are full");

endmodule

// File: rtl/mur_step.sv
// ----------------------------------------------------------------------------
// Ranger step logic
// Holds the counter, channel, trigger and per channel pulse state and works
// out one tick of the ranger from the registered echo sample.
// ----------------------------------------------------------------------------
module mur_step
  import mur_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [2:0]            echo_pins_i,
  input  logic [TICKS_BITS-1:0] trigger_ticks_i,
  output mur_result_t           result_o
);

  logic [COUNTER_BITS-1:0] count_q, count_d;
  channel_e                chan_q, chan_d;
  logic [2:0]              trig_q, trig_d;
  logic [2:0]              prev_q, prev_d;
  logic [COUNTER_BITS-1:0] start_q [NUM_CHANNELS];
  logic [COUNTER_BITS-1:0] start_d [NUM_CHANNELS];
  logic [2:0]              open_q, open_d;
  logic [TIME_BITS-1:0]    time_q [NUM_CHANNELS];
  logic [TIME_BITS-1:0]    time_d [NUM_CHANNELS];

  logic [COUNTER_BITS-1:0] diff;
  logic [31:0]             half;
  logic [2:0]              changed;

  always_comb begin
    count_d = count_q + COUNTER_BITS'(1);
    chan_d  = chan_q;
    trig_d  = trig_q;
    open_d  = open_q;
    start_d = start_q;
    time_d  = time_q;

    if (count_d == '0) begin
      unique case (chan_q)
        CH_LEFT:  chan_d = CH_RIGHT;
        CH_RIGHT: chan_d = CH_FRONT;
        CH_FRONT: chan_d = CH_LEFT;
        default:  chan_d = CH_LEFT;
      endcase
      if (open_d[chan_d]) begin
        open_d[chan_d]  = 1'b0;
        start_d[chan_d] = '0;
        time_d[chan_d]  = TIMEOUT_CODE;
      end
      trig_d[chan_d] = 1'b1;
    end

    if (32'(count_d) == 32'(trigger_ticks_i)) begin
      trig_d[chan_d] = 1'b0;
    end

    changed = echo_pins_i ^ prev_q;
    prev_d  = echo_pins_i;
    diff    = count_d - start_d[chan_d];
    half    = 32'(diff[COUNTER_BITS-1:1]);
    if (changed[chan_d]) begin
      if (open_d[chan_d]) begin
        time_d[chan_d]  = (half > 32'(MAX_WIDTH)) ? MAX_WIDTH : half[TIME_BITS-1:0];
        open_d[chan_d]  = 1'b0;
        start_d[chan_d] = '0;
      end else begin
        start_d[chan_d] = count_d;
        open_d[chan_d]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      chan_q  <= CH_LEFT;
      trig_q  <= '0;
      prev_q  <= '0;
      open_q  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_q[i] <= '0;
        time_q[i]  <= '0;
      end
    end else if (step_i) begin
      count_q <= count_d;
      chan_q  <= chan_d;
      trig_q  <= trig_d;
      prev_q  <= prev_d;
      open_q  <= open_d;
      start_q <= start_d;
      time_q  <= time_d;
    end
  end

  assign result_o.trigger_lines = trig_d;
  assign result_o.active_sensor = chan_d;
  assign result_o.left_time     = time_d[CH_LEFT];
  assign result_o.right_time    = time_d[CH_RIGHT];
  assign result_o.front_time    = time_d[CH_FRONT];

endmodule

// File: rtl/mur_out_reg.sv
// ----------------------------------------------------------------------------
// Ranger output register
// Holds one result word for the master side until it is taken.
// ----------------------------------------------------------------------------
module mur_out_reg
  import mur_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  mur_result_t               result_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // trigger_lines[2:0], active_sensor[4:3], left_time[20:5],
  // right_time[36:21], front_time[52:37], zero fill[55:53]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic        valid_q, valid_d;
  mur_result_t data_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_BITS - $bits(mur_result_t))'(0), data_q};

endmodule
